// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int CAP_W           = 4;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef enum logic
    {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

endpackage

`default_nettype wire

// ===== rtl/lkvc_if.sv =====
// Request and response channel interfaces for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if;
    import lkvc_pkg::*;

    logic               valid;
    logic               ready;
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [VALUE_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_key_value_cache_core.sv =====
// Fully associative key/value cache with least-recently-used replacement.
//
// Usage:
//   req carries one transaction per get (func = FUNC_GET) or put (func = FUNC_PUT)
//   with a key and a value. rsp returns one transaction per request: hit tells
//   whether the key was present, read_value holds the stored value on a get hit
//   and zero otherwise. Results come back in request order.
//   A request is captured in an input register; once the result register is
//   free, all entries are compared in parallel, ranks are updated and the
//   result is registered. Throughput is one transaction per cycle while rsp
//   is not stalled, as the compare and rank update over all entries are
//   combinational.
//   When rsp is stalled, the result register holds and the input register
//   fills; req.ready drops once both are occupied.
//   cfg_wr_en/cfg_wr_data set the capacity (values above ENTRIES act as
//   ENTRIES, zero keeps the store empty); a write while entries are held is
//   dropped.
//   Reset empties the store, sets capacity to 8 and clears both registers.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_core
#(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lkvc_req_if.sink                       req,
    lkvc_rsp_if.source                     rsp,
    input  wire logic                      cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);
    import lkvc_pkg::*;

    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CAP_EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]   capacity_reg;
    logic [CNT_W-1:0]   occupancy_reg;
    logic [CNT_W-1:0]   occupancy_next;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [KEY_W-1:0]   key_mem   [ENTRIES];
    logic [VALUE_W-1:0] value_mem [ENTRIES];

    logic               s1_valid_reg;
    func_t              s1_func_reg;
    logic [KEY_W-1:0]   s1_key_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    logic               rsp_valid_reg;
    logic               rsp_hit_reg;
    logic [VALUE_W-1:0] rsp_data_reg;

    logic               out_free;
    logic               s1_advance;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [VALUE_W-1:0] hit_value;
    logic [IDX_W-1:0]   hit_rank;
    logic [ENTRIES-1:0] free_oh;
    logic               free_found;
    logic [ENTRIES-1:0] victim_oh;
    logic [CAP_EXT_W-1:0] eff_cap;
    logic [CNT_W-1:0]   thr;
    logic [ENTRIES-1:0] target_oh;
    logic               do_update;
    logic               write_key;
    logic               write_value;
    logic [VALUE_W-1:0] rsp_data_next;

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign req.ready  = !s1_valid_reg || out_free;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.read_value = rsp_data_reg;

    assign eff_cap = (CAP_EXT_W'(capacity_reg) > CAP_EXT_W'(ENTRIES)) ?
                     CAP_EXT_W'(ENTRIES) : CAP_EXT_W'(capacity_reg);

    always_comb
    begin
        hit_value  = '0;
        hit_rank   = '0;
        free_oh    = '0;
        free_found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (key_mem[i] == s1_key_reg);
            victim_oh[i] = valid_reg[i] &&
                           (CNT_W'(rank_reg[i]) == (occupancy_reg - CNT_W'(1)));
            hit_value    = hit_value | (match[i] ? value_mem[i] : '0);
            hit_rank     = hit_rank | (match[i] ? rank_reg[i] : '0);
            if (!valid_reg[i] && !free_found)
            begin
                free_oh[i] = 1'b1;
                free_found = 1'b1;
            end
        end
        hit = |match;
    end

    always_comb
    begin
        thr            = '0;
        target_oh      = '0;
        do_update      = 1'b0;
        write_key      = 1'b0;
        write_value    = 1'b0;
        occupancy_next = occupancy_reg;
        rsp_data_next  = '0;
        if (s1_advance)
        begin
            if (hit)
            begin
                do_update   = 1'b1;
                thr         = CNT_W'(hit_rank);
                target_oh   = match;
                write_value = (s1_func_reg == FUNC_PUT);
                if (s1_func_reg == FUNC_GET)
                begin
                    rsp_data_next = hit_value;
                end
            end
            else if (s1_func_reg == FUNC_PUT && eff_cap != '0)
            begin
                do_update   = 1'b1;
                write_key   = 1'b1;
                write_value = 1'b1;
                if (CAP_EXT_W'(occupancy_reg) < eff_cap)
                begin
                    thr            = occupancy_reg;
                    target_oh      = free_oh;
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
                else
                begin
                    thr       = occupancy_reg - CNT_W'(1);
                    target_oh = victim_oh;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (do_update)
            begin
                if (valid_reg[i] && CNT_W'(rank_reg[i]) < thr)
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                if (target_oh[i])
                begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            occupancy_reg <= '0;
            valid_reg     <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && occupancy_reg == '0)
            begin
                capacity_reg <= cfg_wr_data;
            end
            occupancy_reg <= occupancy_next;
            valid_reg     <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg  <= req.func;
            s1_key_reg   <= req.key;
            s1_value_reg <= req.value;
        end
        if (s1_advance)
        begin
            rsp_hit_reg  <= hit;
            rsp_data_reg <= rsp_data_next;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (target_oh[i] && write_key)
            begin
                key_mem[i] <= s1_key_reg;
            end
            if (target_oh[i] && write_value)
            begin
                value_mem[i] <= s1_value_reg;
            end
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occupancy_reg))
        else $error("occupancy does not match number of valid entries");

    a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CAP_EXT_W'(occupancy_reg) <= eff_cap)
        else $error("occupancy exceeds effective capacity");

    a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> rsp_valid_reg)
        else $error("advanced transaction produced no response");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_hit_reg) |-> (rsp_data_reg == '0))
        else $error("miss response carries nonzero data");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(match))
        else $error("key present in more than one entry");

endmodule

`default_nettype wire

// ===== tb/lru_key_value_cache_core_tb.sv =====
// Self-checking testbench: random get/put traffic against an LRU cache predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
    import lkvc_pkg::*;

    localparam int SLOTS     = ENTRIES_DEFAULT;
    localparam int POOL_SIZE = 12;
    localparam int PHASES    = 4;
    localparam int PHASE_LEN = 410;

    typedef struct packed
    {
        func_t              func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } lookup_req_t;

    typedef struct packed
    {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
    } lookup_rsp_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    lkvc_req_if req_if();
    lkvc_rsp_if rsp_if();

    lru_key_value_cache_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lookup_req_t request_backlog[$];
    lookup_rsp_t lookup_results_due[$];
    int          in_flight;
    int          error_count;
    int          send_gap;
    int          stall_left;
    bit          no_idle;

    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    logic [CAP_W-1:0]   ignored_caps[PHASES];

    logic               slot_used[SLOTS];
    logic [KEY_W-1:0]   slot_key[SLOTS];
    logic [VALUE_W-1:0] slot_value[SLOTS];
    int                 slot_age[SLOTS];
    int                 fill_count;
    logic [CAP_W-1:0]   capacity_reg;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void predict_lookup(input lookup_req_t r);
        int          found;
        int          victim;
        int          limit;
        lookup_rsp_t res;
        found = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == r.key)
                found = i;
        res.hit        = (found >= 0);
        res.read_value = '0;
        if (found >= 0)
        begin
            if (r.func == FUNC_GET)
                res.read_value = slot_value[found];
            else
                slot_value[found] = r.value;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_age[i] < slot_age[found])
                    slot_age[i]++;
            slot_age[found] = 0;
        end
        else if (r.func == FUNC_PUT)
        begin
            limit  = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
            victim = -1;
            if (limit > 0 && fill_count < limit)
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        victim = i;
                fill_count++;
            end
            else if (limit > 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                slot_used[victim] = 1'b0;
            end
            if (victim >= 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i])
                        slot_age[i]++;
                slot_used[victim]  = 1'b1;
                slot_key[victim]   = r.key;
                slot_value[victim] = r.value;
                slot_age[victim]   = 0;
            end
        end
        lookup_results_due.push_back(res);
    endfunction

    function automatic void queue_lookup(func_t f, logic [KEY_W-1:0] k,
                                         logic [VALUE_W-1:0] v);
        lookup_req_t r;
        r.func  = f;
        r.key   = k;
        r.value = v;
        request_backlog.push_back(r);
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_backlog.size() != 0 || in_flight != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        if (fill_count == 0)
            capacity_reg = cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lru_key_value_cache_core test failed");
        $finish;
    end

    always @(posedge clk)
    begin : drive_requests
        lookup_req_t accepted;
        lookup_req_t next_req;
        if (rst_n && (!req_if.valid || req_if.ready))
        begin
            if (req_if.valid)
            begin
                accepted.func  = req_if.func;
                accepted.key   = req_if.key;
                accepted.value = req_if.value;
                predict_lookup(accepted);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_if.valid <= 1'b0;
            end
            else if (request_backlog.size() > 0)
            begin
                next_req = request_backlog.pop_front();
                in_flight++;
                req_if.valid <= 1'b1;
                req_if.func  <= next_req.func;
                req_if.key   <= next_req.key;
                req_if.value <= next_req.value;
                send_gap = idle_length();
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_responses
        lookup_rsp_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (lookup_results_due.size() == 0)
                    report_mismatch("unexpected transaction", rsp_if.read_value, 0);
                else
                begin
                    want = lookup_results_due.pop_front();
                    in_flight--;
                    if (rsp_if.hit !== want.hit)
                        report_mismatch("hit", rsp_if.hit, want.hit);
                    if (rsp_if.read_value !== want.read_value)
                        report_mismatch("read_value", rsp_if.read_value, want.read_value);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
                rsp_if.ready <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        req_if.valid = 1'b0;
        req_if.func  = FUNC_GET;
        req_if.key   = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        in_flight    = 0;
        error_count  = 0;
        send_gap     = 0;
        stall_left   = 0;
        no_idle      = 1'b0;
        fill_count   = 0;
        capacity_reg = CAP_RESET;
        ignored_caps = '{4'd1, 4'd0, 4'd15, 4'd3};
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_age[i]   = 0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, capacity above the entry count
        write_capacity(4'd15);
        queue_lookup(FUNC_GET, '0, '1);
        queue_lookup(FUNC_GET, '1, '0);
        wait_idle();

        // zero capacity: puts are dropped at once
        write_capacity(4'd0);
        queue_lookup(FUNC_PUT, 32'h0000_0005, 32'hdead_beef);
        queue_lookup(FUNC_GET, 32'h0000_0005, '0);
        queue_lookup(FUNC_PUT, '1, '1);
        queue_lookup(FUNC_GET, '1, '1);
        wait_idle();

        // fill, hit, update, evict the least recent
        write_capacity(4'd12);
        queue_lookup(FUNC_PUT, '0, '1);
        queue_lookup(FUNC_PUT, '1, '0);
        for (int i = 2; i < SLOTS; i++)
            queue_lookup(FUNC_PUT, i, $urandom());
        queue_lookup(FUNC_GET, '0, $urandom());
        queue_lookup(FUNC_PUT, '0, $urandom());
        queue_lookup(FUNC_PUT, SLOTS, $urandom());
        queue_lookup(FUNC_GET, '1, '0);
        queue_lookup(FUNC_GET, SLOTS, '0);
        queue_lookup(FUNC_GET, 32'h0000_0002, '0);
        wait_idle();

        // capacity write with entries held is dropped
        write_capacity(4'd1);
        queue_lookup(FUNC_PUT, SLOTS + 1, $urandom());
        queue_lookup(FUNC_GET, '0, '0);
        queue_lookup(FUNC_GET, 32'h0000_0003, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            write_capacity(ignored_caps[phase]);
            no_idle = (phase == 1);
            for (int i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom();
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (phase == 2 && n == PHASE_LEN / 2)
                    wait_idle();
                k = ($urandom_range(0, 6) == 0) ? $urandom()
                                                : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                queue_lookup($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, k, $urandom());
            end
        end
        no_idle = 1'b0;
        wait_idle();

        if (lookup_results_due.size() != 0)
            report_mismatch("missing transactions", 0, lookup_results_due.size());

        if (error_count == 0)
            $display("lru_key_value_cache_core test passed");
        else
            $display("lru_key_value_cache_core test failed");
        $finish;
    end

endmodule
